### rtl/hmsda_pkg.sv
// shared types, constants and helper functions of the hh:mm:ss duration adjuster
`default_nettype none

package hmsda_pkg;

    localparam int DIGIT_W     = 4;
    localparam int DIGIT_COUNT = 6;
    localparam int TOTAL_W     = 19;
    localparam int SECS_IN_W   = 20;
    localparam int HOURS_W     = 7;
    localparam int REM_W       = 12;
    localparam int MINS_W      = 6;

    // largest duration that the seconds path stores (99:59:59)
    localparam logic [TOTAL_W-1:0] MAX_TOTAL = 19'd359999;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    // reciprocal multipliers, exact for totals up to MAX_TOTAL and remainders below an hour
    localparam int HOUR_RECIP = 298262;
    localparam int HOUR_SHIFT = 30;
    localparam int MIN_RECIP  = 4370;
    localparam int MIN_SHIFT  = 18;

    typedef enum logic [1:0] {
        ACT_ADJUST       = 2'd0,
        ACT_LOAD_DIGITS  = 2'd1,
        ACT_LOAD_SECONDS = 2'd2
    } action_t;

    // what the back end does with a queued item
    typedef enum logic [1:0] {
        KIND_CONVERT = 2'd0,
        KIND_RAW     = 2'd1,
        KIND_HOLD    = 2'd2
    } kind_t;

    // digit 0 is hours tens, digit 5 is seconds ones
    typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        kind_t                kind;
        logic [TOTAL_W-1:0]   total;
        digits_t              digits;
        logic                 clip;
    } item_t;

    // split a value below one hundred into tens (index 0) and ones (index 1)
    function automatic logic [1:0][DIGIT_W-1:0] bcd_split(input logic [6:0] x);
        logic [DIGIT_W-1:0]    tens;
        logic [6:0]            ones_w;
        logic [1:0][DIGIT_W-1:0] res;
        tens = '0;
        for (int i = 1; i <= 9; i++) begin
            if (x >= 7'(10 * i)) begin
                tens = tens + 4'd1;
            end
        end
        ones_w = x - 7'(7'(tens) * 7'd10);
        res[0] = tens;
        res[1] = ones_w[DIGIT_W-1:0];
        return res;
    endfunction

    // digits above nine are stored as nine
    function automatic logic [DIGIT_W-1:0] sat9(input logic [DIGIT_W-1:0] d);
        return (d > 4'd9) ? 4'd9 : d;
    endfunction

endpackage

`default_nettype wire

### rtl/hmsda_front.sv
// front end: accepts actions, keeps the running total in seconds and classifies each item
`default_nettype none

module hmsda_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [63:0]        s_tdata,
    input  wire logic [7:0]         s_tuser,
    input  wire logic               q_full,
    output logic                    q_push,
    output hmsda_pkg::item_t        q_item
);

    logic [hmsda_pkg::TOTAL_W-1:0] total_reg;
    logic [hmsda_pkg::TOTAL_W-1:0] total_next;

    hmsda_pkg::action_t            action;
    hmsda_pkg::digits_t            raw_digits;
    logic [6:0]                    raw_hrs;
    logic [6:0]                    raw_mins;
    logic [6:0]                    raw_secs;
    logic [hmsda_pkg::TOTAL_W-1:0] raw_total;
    logic signed [20:0]            delta_ext;
    logic signed [20:0]            load_ext;
    logic signed [20:0]            cur_ext;
    logic signed [20:0]            sum_sel;
    logic [hmsda_pkg::TOTAL_W-1:0] clamp_total;
    logic                          clamp_hit;

    assign action   = hmsda_pkg::action_t'(s_tuser[1:0]);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // saturated load digits and their value in seconds
    always_comb begin
        for (int i = 0; i < hmsda_pkg::DIGIT_COUNT; i++) begin
            raw_digits[i] = hmsda_pkg::sat9(s_tdata[40 + 4*i +: 4]);
        end
        raw_hrs   = 7'(7'(raw_digits[0]) * 7'd10) + 7'(raw_digits[1]);
        raw_mins  = 7'(7'(raw_digits[2]) * 7'd10) + 7'(raw_digits[3]);
        raw_secs  = 7'(7'(raw_digits[4]) * 7'd10) + 7'(raw_digits[5]);
        raw_total = 19'(19'(raw_hrs) * 19'(hmsda_pkg::SECS_PER_HOUR))
                  + 19'(19'(raw_mins) * 19'(hmsda_pkg::SECS_PER_MIN))
                  + 19'(raw_secs);
    end

    // adjust sum or load total, then clamp to the storable range
    always_comb begin
        delta_ext = {s_tdata[19], s_tdata[19:0]};
        load_ext  = {s_tdata[39], s_tdata[39:20]};
        cur_ext   = {2'b00, total_reg};
        sum_sel   = (action == hmsda_pkg::ACT_ADJUST) ? (cur_ext + delta_ext) : load_ext;
        priority if (sum_sel < 21'sd0) begin
            clamp_total = '0;
            clamp_hit   = 1'b1;
        end else if (sum_sel > 21'sd359999) begin
            clamp_total = hmsda_pkg::MAX_TOTAL;
            clamp_hit   = 1'b1;
        end else begin
            clamp_total = sum_sel[hmsda_pkg::TOTAL_W-1:0];
            clamp_hit   = 1'b0;
        end
    end

    // classify the item for the back end
    always_comb begin
        q_item.digits = raw_digits;
        unique case (action)
            hmsda_pkg::ACT_ADJUST, hmsda_pkg::ACT_LOAD_SECONDS: begin
                q_item.kind  = hmsda_pkg::KIND_CONVERT;
                q_item.total = clamp_total;
                q_item.clip  = clamp_hit;
            end
            hmsda_pkg::ACT_LOAD_DIGITS: begin
                q_item.kind  = hmsda_pkg::KIND_RAW;
                q_item.total = raw_total;
                q_item.clip  = 1'b0;
            end
            default: begin
                q_item.kind  = hmsda_pkg::KIND_HOLD;
                q_item.total = total_reg;
                q_item.clip  = 1'b0;
            end
        endcase
    end

    // running total follows every accepted transfer
    assign total_next = q_push ? q_item.total : total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else begin
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

### rtl/hmsda_queue.sv
// short queue of classified items between front and back end
`default_nettype none

module hmsda_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire hmsda_pkg::item_t  push_item,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output hmsda_pkg::item_t       head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hmsda_pkg::item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/hmsda_back.sv
// back end: seconds to hh:mm:ss digits pipeline and output register
`default_nettype none

module hmsda_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire hmsda_pkg::item_t  q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,
    output logic [7:0]             m_tuser
);

    logic advance;

    logic                               st1_valid_reg;
    hmsda_pkg::item_t                   st1_item_reg;
    logic [hmsda_pkg::HOURS_W-1:0]      st1_hours_reg;

    logic                               st2_valid_reg;
    hmsda_pkg::item_t                   st2_item_reg;
    logic [hmsda_pkg::HOURS_W-1:0]      st2_hours_reg;
    logic [hmsda_pkg::REM_W-1:0]        st2_rem_reg;

    logic                               st3_valid_reg;
    hmsda_pkg::item_t                   st3_item_reg;
    logic [hmsda_pkg::HOURS_W-1:0]      st3_hours_reg;
    logic [hmsda_pkg::REM_W-1:0]        st3_rem_reg;
    logic [hmsda_pkg::MINS_W-1:0]       st3_mins_reg;

    logic                               out_valid_reg, out_valid_next;
    hmsda_pkg::digits_t                 out_digits_reg, out_digits_next;
    logic [hmsda_pkg::TOTAL_W-1:0]      out_total_reg;
    logic                               out_clip_reg;

    logic [37:0]                        hour_prod;
    logic [18:0]                        hour_x3600;
    logic [18:0]                        rem_full;
    logic [24:0]                        min_prod;
    logic [11:0]                        min_x60;
    logic [11:0]                        secs_full;
    logic [1:0][hmsda_pkg::DIGIT_W-1:0] h_split, m_split, s_split;

    // the whole pipeline moves when the output register can take a transfer
    assign advance = !out_valid_reg || m_tready;
    assign q_pop   = advance && q_valid;

    // stage arithmetic
    always_comb begin
        hour_prod  = 38'(q_item.total) * 38'(hmsda_pkg::HOUR_RECIP);
        hour_x3600 = 19'(19'(st1_hours_reg) * 19'(hmsda_pkg::SECS_PER_HOUR));
        rem_full   = st1_item_reg.total - hour_x3600;
        min_prod   = 25'(st2_rem_reg) * 25'(hmsda_pkg::MIN_RECIP);
        min_x60    = 12'(12'(st3_mins_reg) * 12'(hmsda_pkg::SECS_PER_MIN));
        secs_full  = st3_rem_reg - min_x60;
        h_split    = hmsda_pkg::bcd_split(st3_hours_reg);
        m_split    = hmsda_pkg::bcd_split(7'(st3_mins_reg));
        s_split    = hmsda_pkg::bcd_split(7'(secs_full[5:0]));
    end

    // digit selection for the output register
    always_comb begin
        out_digits_next = out_digits_reg;
        out_valid_next  = out_valid_reg;
        if (advance) begin
            out_valid_next = st3_valid_reg;
            if (st3_valid_reg) begin
                unique case (st3_item_reg.kind)
                    hmsda_pkg::KIND_CONVERT: begin
                        out_digits_next[0] = h_split[0];
                        out_digits_next[1] = h_split[1];
                        out_digits_next[2] = m_split[0];
                        out_digits_next[3] = m_split[1];
                        out_digits_next[4] = s_split[0];
                        out_digits_next[5] = s_split[1];
                    end
                    hmsda_pkg::KIND_RAW: begin
                        out_digits_next = st3_item_reg.digits;
                    end
                    default: begin
                        // hold: digits of the previous result stay
                        out_digits_next = out_digits_reg;
                    end
                endcase
            end
        end
    end

    // control state and the digit store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg  <= 1'b0;
            st2_valid_reg  <= 1'b0;
            st3_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_digits_reg <= '0;
        end else begin
            if (advance) begin
                st1_valid_reg <= q_valid;
                st2_valid_reg <= st1_valid_reg;
                st3_valid_reg <= st2_valid_reg;
            end
            out_valid_reg  <= out_valid_next;
            out_digits_reg <= out_digits_next;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_item_reg  <= q_item;
            st1_hours_reg <= hour_prod[hmsda_pkg::HOUR_SHIFT +: hmsda_pkg::HOURS_W];
            st2_item_reg  <= st1_item_reg;
            st2_hours_reg <= st1_hours_reg;
            st2_rem_reg   <= rem_full[hmsda_pkg::REM_W-1:0];
            st3_item_reg  <= st2_item_reg;
            st3_hours_reg <= st2_hours_reg;
            st3_rem_reg   <= st2_rem_reg;
            st3_mins_reg  <= min_prod[hmsda_pkg::MIN_SHIFT +: hmsda_pkg::MINS_W];
            if (st3_valid_reg) begin
                out_total_reg <= st3_item_reg.total;
                out_clip_reg  <= st3_item_reg.clip;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_total_reg, out_digits_reg};
    assign m_tuser  = {7'b0, out_clip_reg};

`ifndef NO_ASSERTIONS
    a_rem_below_hour: assert property (@(posedge aclk) disable iff (!aresetn)
        st2_valid_reg && (st2_item_reg.kind == hmsda_pkg::KIND_CONVERT)
        |-> (st2_rem_reg < 12'd3600) && (st2_hours_reg <= 7'd99))
        else $error("hour split left a remainder of an hour or more");

    a_mins_below_sixty: assert property (@(posedge aclk) disable iff (!aresetn)
        st3_valid_reg && (st3_item_reg.kind == hmsda_pkg::KIND_CONVERT)
        |-> (st3_mins_reg < 6'd60) && (secs_full < 12'd60))
        else $error("minute split out of range");

    a_clip_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_clip_reg
        |-> (out_total_reg == '0) || (out_total_reg == hmsda_pkg::MAX_TOTAL))
        else $error("clamped result not at a range limit");
`endif

endmodule

`default_nettype wire

### rtl/hms_digit_duration_adjuster.sv
// top level of the hh:mm:ss duration adjuster
`default_nettype none

// Keeps an HH:MM:SS duration as six decimal digits and answers every accepted
// action (adjust by a signed delta, load six digits, load a total in seconds)
// with one result carrying the stored digits, their value in seconds and a
// clamp flag. One action is accepted per clock cycle, sustained while the
// queue is not full, also when every action depends on the one before: the
// front end holds the running total in seconds and updates it in the accept
// cycle, so only that one add and clamp sits in the loop. The digit
// conversion runs afterwards, behind the queue, in a four-register back end.
// Up to QUEUE_DEPTH classified actions wait between the two halves, so
// s_tready only drops once the queue is full.
module hms_digit_duration_adjuster #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // adjust_delta [19:0], load_seconds [39:20], hours_tens_in [43:40],
    // hours_ones_in [47:44], minutes_tens_in [51:48], minutes_ones_in [55:52],
    // seconds_tens_in [59:56], seconds_ones_in [63:60]
    input  wire logic [63:0] s_tdata,
    // action [1:0], zero above
    input  wire logic [7:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // hours_tens [3:0], hours_ones [7:4], minutes_tens [11:8],
    // minutes_ones [15:12], seconds_tens [19:16], seconds_ones [23:20],
    // duration_secs [42:24], zero above
    output logic [47:0]      m_tdata,
    // clamped [0], zero above
    output logic [7:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;
    hmsda_pkg::item_t push_item;
    hmsda_pkg::item_t head_item;

    // accept and classify
    hmsda_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // decoupling queue
    hmsda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // digit conversion and result transfer
    hmsda_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### verif/hms_digit_duration_adjuster_tb.sv
// self-checking testbench of the hh:mm:ss duration adjuster
module hms_digit_duration_adjuster_tb;

    // unused action code, must leave the digit store alone
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ACTIONS = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [hmsda_pkg::TOTAL_W-1:0] total;
        hmsda_pkg::digits_t            digits;
        logic                          clamped;
    } duration_result_t;

    typedef struct {
        logic [1:0]             act;
        logic signed [19:0]     delta;
        logic signed [19:0]     load;
        hmsda_pkg::digits_t     digits;
        bit                     typed;
        duration_result_t       want;
    } action_row_t;

    logic        aclk;
    logic        aresetn;
    logic [63:0] s_tdata;
    logic [7:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;

    // typed-in expectation travelling alongside the transfer on the bus
    bit               row_typed;
    duration_result_t row_want;

    hmsda_pkg::digits_t stored_digits;
    duration_result_t   pending_results[$];
    action_row_t        directed_rows[$];
    int                 errors;
    int                 idle_cycles;
    bit                 send_burst;
    bit                 recv_burst;

    hms_digit_duration_adjuster dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    // digits written as they read, hours tens in the top nibble
    function automatic hmsda_pkg::digits_t hms(input logic [23:0] bcd);
        hmsda_pkg::digits_t d;
        for (int i = 0; i < hmsda_pkg::DIGIT_COUNT; i++) begin
            d[i] = bcd[23-4*i -: 4];
        end
        return d;
    endfunction

    function automatic int digits_to_seconds(input hmsda_pkg::digits_t d);
        return (int'(d[0]) * 10 + int'(d[1])) * hmsda_pkg::SECS_PER_HOUR
             + (int'(d[2]) * 10 + int'(d[3])) * hmsda_pkg::SECS_PER_MIN
             + int'(d[4]) * 10 + int'(d[5]);
    endfunction

    // clamp a signed total into the store, flag whether it was limited
    function automatic logic store_seconds(input int secs);
        logic clip;
        int   hh;
        int   mm;
        int   ss;
        clip = 1'b0;
        if (secs < 0) begin
            secs = 0;
            clip = 1'b1;
        end else if (secs > int'(hmsda_pkg::MAX_TOTAL)) begin
            secs = int'(hmsda_pkg::MAX_TOTAL);
            clip = 1'b1;
        end
        hh = secs / hmsda_pkg::SECS_PER_HOUR;
        mm = (secs % hmsda_pkg::SECS_PER_HOUR) / hmsda_pkg::SECS_PER_MIN;
        ss = secs % hmsda_pkg::SECS_PER_MIN;
        stored_digits[0] = 4'(hh / 10);
        stored_digits[1] = 4'(hh % 10);
        stored_digits[2] = 4'(mm / 10);
        stored_digits[3] = 4'(mm % 10);
        stored_digits[4] = 4'(ss / 10);
        stored_digits[5] = 4'(ss % 10);
        return clip;
    endfunction

    // next state of the duration store and the result it reports
    function automatic duration_result_t apply_action(input logic [1:0] act,
                                                      input logic signed [19:0] delta,
                                                      input logic signed [19:0] load,
                                                      input hmsda_pkg::digits_t digits_in);
        duration_result_t res;
        res.clamped = 1'b0;
        case (act)
            hmsda_pkg::ACT_ADJUST: begin
                res.clamped = store_seconds(digits_to_seconds(stored_digits) + int'(delta));
            end
            hmsda_pkg::ACT_LOAD_DIGITS: begin
                for (int i = 0; i < hmsda_pkg::DIGIT_COUNT; i++) begin
                    stored_digits[i] = (digits_in[i] > 4'd9) ? 4'd9 : digits_in[i];
                end
            end
            hmsda_pkg::ACT_LOAD_SECONDS: begin
                res.clamped = store_seconds(int'(load));
            end
            default: begin
                // unused code, store kept
            end
        endcase
        res.digits = stored_digits;
        res.total  = hmsda_pkg::TOTAL_W'(digits_to_seconds(stored_digits));
        return res;
    endfunction

    task automatic queue_directed(input logic [1:0] act, input int delta, input int load,
                                  input logic [23:0] digs, input bit typed,
                                  input logic [23:0] want_digs, input int want_total,
                                  input bit want_clamp);
        action_row_t r;
        r.act          = act;
        r.delta        = 20'(delta);
        r.load         = 20'(load);
        r.digits       = hms(digs);
        r.typed        = typed;
        r.want.digits  = hms(want_digs);
        r.want.total   = hmsda_pkg::TOTAL_W'(want_total);
        r.want.clamped = want_clamp;
        directed_rows.push_back(r);
    endtask

    function automatic action_row_t random_row();
        action_row_t r;
        int          pick;
        pick = $urandom_range(0, 99);
        r.act = (pick < 40) ? hmsda_pkg::ACT_ADJUST :
                (pick < 60) ? hmsda_pkg::ACT_LOAD_DIGITS :
                (pick < 92) ? hmsda_pkg::ACT_LOAD_SECONDS : ACT_UNUSED;
        // mostly small steps, some full-range and edge deltas
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            r.delta = 20'(int'($urandom_range(0, 8000)) - 4000);
        end else if (pick < 8) begin
            r.delta = 20'($urandom);
        end else if (pick == 8) begin
            r.delta = $urandom_range(0, 1) ? 20'sd1 : -20'sd1;
        end else begin
            r.delta = 20'(int'($urandom_range(0, 2 * 359999)) - 359999);
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            r.load = 20'($urandom_range(0, 359999));
        end else if (pick < 9) begin
            r.load = 20'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: r.load = 20'sd0;
                1: r.load = 20'sd359999;
                2: r.load = -20'sd1;
                default: r.load = 20'sd360000;
            endcase
        end
        // digits mostly well-formed, now and then raw nibbles
        for (int i = 0; i < hmsda_pkg::DIGIT_COUNT; i++) begin
            r.digits[i] = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9)) : 4'($urandom);
        end
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // drive one action and hold it until the transfer
    task automatic send_action(input action_row_t r);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {r.digits, r.load, r.delta};
        s_tuser   <= {6'd0, r.act};
        row_typed <= r.typed;
        row_want  <= r.want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if ($urandom_range(0, 39) == 0) begin
            send_burst = ~send_burst;
        end
    endtask

    // result checking, prediction on each input transfer, and the watchdog count
    always @(posedge aclk) begin : result_check
        duration_result_t got;
        duration_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.digits  = m_tdata[23:0];
                got.total   = m_tdata[42:24];
                got.clamped = m_tuser[0];
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: expected no result, got digits %h total %0d clamp %0b",
                             $time, got.digits, got.total, got.clamped);
                end else begin
                    want = pending_results.pop_front();
                    for (int i = 0; i < hmsda_pkg::DIGIT_COUNT; i++) begin
                        if (got.digits[i] !== want.digits[i]) begin
                            errors++;
                            $display("%0t: digit %0d expected %0d got %0d",
                                     $time, i, want.digits[i], got.digits[i]);
                        end
                    end
                    if (got.total !== want.total) begin
                        errors++;
                        $display("%0t: duration_secs expected %0d got %0d",
                                 $time, want.total, got.total);
                    end
                    if (got.clamped !== want.clamped) begin
                        errors++;
                        $display("%0t: clamped expected %0b got %0b",
                                 $time, want.clamped, got.clamped);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_action(s_tuser[1:0], s_tdata[19:0], s_tdata[39:20],
                                    s_tdata[63:40]);
                pending_results.push_back(row_typed ? row_want : want);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // result side: random back-pressure with bursts of none
    initial begin : result_sink
        int gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = recv_burst ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
            if ($urandom_range(0, 39) == 0) begin
                recv_burst = ~recv_burst;
            end
        end
    end

    initial begin : stimulus
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tvalid      = 1'b0;
        m_tready      = 1'b0;
        row_typed     = 1'b0;
        row_want      = '0;
        stored_digits = '0;
        errors        = 0;
        idle_cycles   = 0;
        send_burst    = 1'b0;
        recv_burst    = 1'b0;

        // directed rows: action, delta, load, digits, typed, digits, total, clamp
        queue_directed(hmsda_pkg::ACT_ADJUST,  0, 0, 24'h000000, 1, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_LOAD_SECONDS, 0, 359999, 24'h000000,
                       1, 24'h995959, 359999, 0);
        queue_directed(hmsda_pkg::ACT_ADJUST,  1, 0, 24'h000000, 1, 24'h995959, 359999, 1);
        queue_directed(hmsda_pkg::ACT_LOAD_SECONDS, 0, -524288, 24'h000000,
                       1, 24'h000000, 0, 1);
        queue_directed(hmsda_pkg::ACT_LOAD_SECONDS, 0, 524287, 24'h000000,
                       1, 24'h995959, 359999, 1);
        queue_directed(hmsda_pkg::ACT_LOAD_DIGITS, 0, 0, 24'h999999,
                       1, 24'h999999, 362439, 0);
        // stored value above the top, zero delta still clamps
        queue_directed(hmsda_pkg::ACT_ADJUST,  0, 0, 24'h000000, 1, 24'h995959, 359999, 1);
        queue_directed(hmsda_pkg::ACT_LOAD_DIGITS, -1, -1, 24'hFFFFFF,
                       1, 24'h999999, 362439, 0);
        queue_directed(ACT_UNUSED, -524288, 524287, 24'hA5A5A5, 1, 24'h999999, 362439, 0);
        queue_directed(hmsda_pkg::ACT_LOAD_DIGITS, 0, 0, 24'h000000, 1, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_ADJUST, -1, 0, 24'h000000, 1, 24'h000000, 0, 1);
        queue_directed(hmsda_pkg::ACT_ADJUST, 524287, 0, 24'h000000,
                       1, 24'h995959, 359999, 1);
        queue_directed(hmsda_pkg::ACT_ADJUST, -524288, 0, 24'h000000, 1, 24'h000000, 0, 1);
        queue_directed(hmsda_pkg::ACT_LOAD_SECONDS, 0, 0, 24'h000000, 1, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_LOAD_SECONDS, 0, 3661, 24'h000000,
                       1, 24'h010101, 3661, 0);
        // checked against the predictor
        queue_directed(hmsda_pkg::ACT_ADJUST, 59, 0, 24'h5A5A5A, 0, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_LOAD_DIGITS, 0, 0, 24'h123456, 0, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_ADJUST, -45296, 0, 24'h000000, 0, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_LOAD_DIGITS, 0, 0, 24'h9A0BFC, 0, 24'h000000, 0, 0);
        queue_directed(ACT_UNUSED, 12345, -7, 24'h000000, 0, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_LOAD_SECONDS, 0, 359998, 24'h000000,
                       0, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_ADJUST, 1, 0, 24'h000000, 0, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_ADJUST, -359999, 0, 24'h000000, 0, 24'h000000, 0, 0);
        queue_directed(hmsda_pkg::ACT_LOAD_SECONDS, 0, -1, 24'h000000, 0, 24'h000000, 0, 0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        fork
            begin
                foreach (directed_rows[i]) begin
                    send_action(directed_rows[i]);
                end
                repeat (RANDOM_ACTIONS) begin
                    send_action(random_row());
                end
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
                repeat (DRAIN_CYCLES) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
            end
        join_any

        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results pending",
                     $time, idle_cycles, pending_results.size());
            $display("TEST FAILED");
        end else if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/hmsda_pkg.sv
rtl/hmsda_front.sv
rtl/hmsda_queue.sv
rtl/hmsda_back.sv
rtl/hms_digit_duration_adjuster.sv
verif/hms_digit_duration_adjuster_tb.sv
